// File: rtl/core/pett_pkg.sv
// ----------------------------------------------------------------------------
// pett_pkg
// Types and constants of the periodic expiring timer table.
// ----------------------------------------------------------------------------
package pett_pkg;

    typedef enum logic [1:0] {
        OP_APPLY   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_FLUSH   = 2'd3
    } t_op;

    localparam logic [1:0] POL_INSTANT = 2'd0;
    localparam logic [1:0] POL_FIXED   = 2'd1;

    localparam logic [2:0] EV_APPLIED  = 3'd0;
    localparam logic [2:0] EV_TICKED   = 3'd1;
    localparam logic [2:0] EV_REMOVED  = 3'd2;
    localparam logic [2:0] EV_NOTFOUND = 3'd3;
    localparam logic [2:0] EV_FULL     = 3'd4;

    localparam logic [3:0] MAX_RESULTS = 4'd8;
    localparam logic [4:0] DIV_LAST    = 5'd24;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] effect_kind;
        logic [1:0]  policy;
        logic [23:0] tick_period;
        logic [23:0] lifetime;
        logic [15:0] elapsed_ms;
        logic [31:0] target_id;
        logic [2:0]  why;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] kind_out;
        logic [31:0] instance_out;
        logic [2:0]  reason_out;
        logic [15:0] tick_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0]        kind;
        logic [31:0]        id;
        logic [1:0]         policy;
        logic [23:0]        period;
        logic [23:0]        phase;
        logic signed [24:0] remaining;
        logic               pending;
        logic [2:0]         why;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY_RM,
        ST_ADV_SCAN,
        ST_ADV_DIV,
        ST_RM_SCAN,
        ST_FLUSH,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/periodic_expiring_timer_table_unit.sv
// ----------------------------------------------------------------------------
// periodic_expiring_timer_table_unit
// Compact insertion-ordered table of timed entries with tick and expiry events.
// ----------------------------------------------------------------------------
// channel   signals               beat taken when
// item in   start, busy, i_item   start high, busy low
// result    o_strobe, o_result    o_strobe high (one cycle, never held off)
//
// Apply writes the next free slot; remove by id walks the table.
// Advance visits every entry in turn; each periodic entry runs the shared
// restoring divider, one quotient bit per cycle.
// Flush walks the table and removes pending entries, at most MAX_RESULTS.
// Reset empties the table and sets the next id to one; results cannot stall.
// ----------------------------------------------------------------------------
module periodic_expiring_timer_table_unit #(
    parameter int MAX_ENTRIES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pett_pkg::t_in    i_item,
    output logic             o_strobe,
    output pett_pkg::t_out   o_result
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    pett_pkg::t_state r_state, n_state;
    pett_pkg::t_entry r_tab [MAX_ENTRIES];
    pett_pkg::t_entry n_tab [MAX_ENTRIES];
    pett_pkg::t_in    r_in, n_in;
    pett_pkg::t_out   r_hold, n_hold, r_out, n_out;
    logic             r_hold_vld, n_hold_vld, r_strobe, n_strobe;
    logic [CW-1:0]    r_count, n_count, r_idx, n_idx;
    logic [31:0]      r_next_id, n_next_id;
    logic [3:0]       r_n, n_n;
    logic [23:0]      r_div_r, n_div_r;
    logic [24:0]      r_div_d, n_div_d;
    logic [4:0]       r_div_cnt, n_div_cnt;

    logic             new_vld;
    pett_pkg::t_out   new_res;
    pett_pkg::t_entry ent, upd;
    logic [24:0]      trial;
    logic             qbit;
    logic [IW-1:0]    idx;

    assign busy     = (r_state != pett_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;
    assign idx      = r_idx[IW-1:0];
    assign ent      = r_tab[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pett_pkg::ST_IDLE;
            r_count    <= '0;
            r_next_id  <= 32'd1;
            r_hold_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_next_id  <= n_next_id;
            r_hold_vld <= n_hold_vld;
            r_strobe   <= n_strobe;
        end
        r_tab     <= n_tab;
        r_in      <= n_in;
        r_hold    <= n_hold;
        r_out     <= n_out;
        r_idx     <= n_idx;
        r_n       <= n_n;
        r_div_r   <= n_div_r;
        r_div_d   <= n_div_d;
        r_div_cnt <= n_div_cnt;
    end

    always_comb begin
        n_state   = r_state;
        n_tab     = r_tab;
        n_in      = r_in;
        n_count   = r_count;
        n_idx     = r_idx;
        n_next_id = r_next_id;
        n_n       = r_n;
        n_div_r   = r_div_r;
        n_div_d   = r_div_d;
        n_div_cnt = r_div_cnt;
        new_vld   = 1'b0;
        new_res   = '0;
        upd       = ent;
        trial     = {r_div_r, r_div_d[24]};
        qbit      = (trial >= {1'b0, ent.period});

        unique case (r_state)
            pett_pkg::ST_IDLE: begin
                if (start) begin
                    n_in  = i_item;
                    n_idx = '0;
                    n_n   = '0;
                    unique case (pett_pkg::t_op'(i_item.op))
                        pett_pkg::OP_APPLY: begin
                            new_vld          = 1'b1;
                            new_res.kind_out = i_item.effect_kind;
                            if (i_item.policy != pett_pkg::POL_INSTANT
                                    && r_count == FULL_COUNT) begin
                                new_res.event_res = pett_pkg::EV_FULL;
                                n_state           = pett_pkg::ST_DONE;
                            end else begin
                                new_res.event_res    = pett_pkg::EV_APPLIED;
                                new_res.instance_out = r_next_id;
                                n_next_id            = r_next_id + 32'd1;
                                if (i_item.policy == pett_pkg::POL_INSTANT) begin
                                    n_state = pett_pkg::ST_APPLY_RM;
                                end else begin
                                    upd.kind    = i_item.effect_kind;
                                    upd.id      = r_next_id;
                                    upd.policy  = i_item.policy;
                                    upd.period  = i_item.tick_period;
                                    upd.phase   = '0;
                                    upd.pending = 1'b0;
                                    upd.why     = '0;
                                    if (i_item.policy == pett_pkg::POL_FIXED) begin
                                        upd.remaining = $signed({1'b0, i_item.lifetime});
                                    end else begin
                                        upd.remaining = '1;
                                    end
                                    n_tab[r_count[IW-1:0]] = upd;
                                    n_count = r_count + CW'(1);
                                    n_state = pett_pkg::ST_DONE;
                                end
                            end
                        end
                        pett_pkg::OP_ADVANCE: begin
                            n_state = (i_item.elapsed_ms == '0) ? pett_pkg::ST_DONE
                                                                : pett_pkg::ST_ADV_SCAN;
                        end
                        pett_pkg::OP_REMOVE: n_state = pett_pkg::ST_RM_SCAN;
                        pett_pkg::OP_FLUSH:  n_state = pett_pkg::ST_FLUSH;
                        default:             n_state = pett_pkg::ST_DONE;
                    endcase
                end
            end
            pett_pkg::ST_APPLY_RM: begin
                new_vld              = 1'b1;
                new_res.event_res    = pett_pkg::EV_REMOVED;
                new_res.kind_out     = r_in.effect_kind;
                new_res.instance_out = r_next_id - 32'd1;
                n_state              = pett_pkg::ST_DONE;
            end
            pett_pkg::ST_ADV_SCAN: begin
                if (r_idx >= r_count) begin
                    n_state = pett_pkg::ST_DONE;
                end else if (ent.pending) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    if (ent.policy == pett_pkg::POL_FIXED) begin
                        upd.remaining = ent.remaining - $signed({9'd0, r_in.elapsed_ms});
                        if (upd.remaining[24] || upd.remaining == '0) begin
                            upd.pending = 1'b1;
                            upd.why     = '0;
                        end
                        n_tab[idx] = upd;
                    end
                    if (ent.period != '0) begin
                        n_div_r   = '0;
                        n_div_d   = {1'b0, ent.phase} + {9'd0, r_in.elapsed_ms};
                        n_div_cnt = '0;
                        n_state   = pett_pkg::ST_ADV_DIV;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            pett_pkg::ST_ADV_DIV: begin
                n_div_r   = qbit ? 24'(trial - {1'b0, ent.period}) : trial[23:0];
                n_div_d   = {r_div_d[23:0], qbit};
                n_div_cnt = r_div_cnt + 5'd1;
                if (r_div_cnt == pett_pkg::DIV_LAST) begin
                    upd.phase  = n_div_r;
                    n_tab[idx] = upd;
                    if (n_div_d != '0 && r_n < pett_pkg::MAX_RESULTS) begin
                        new_vld              = 1'b1;
                        new_res.event_res    = pett_pkg::EV_TICKED;
                        new_res.kind_out     = ent.kind;
                        new_res.instance_out = ent.id;
                        new_res.tick_count   = n_div_d[15:0];
                        n_n                  = r_n + 4'd1;
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = pett_pkg::ST_ADV_SCAN;
                end
            end
            pett_pkg::ST_RM_SCAN: begin
                if (r_idx >= r_count) begin
                    new_vld              = 1'b1;
                    new_res.event_res    = pett_pkg::EV_NOTFOUND;
                    new_res.instance_out = r_in.target_id;
                    n_state              = pett_pkg::ST_DONE;
                end else if (ent.id == r_in.target_id) begin
                    new_vld              = 1'b1;
                    new_res.event_res    = pett_pkg::EV_REMOVED;
                    new_res.kind_out     = ent.kind;
                    new_res.instance_out = ent.id;
                    new_res.reason_out   = r_in.why;
                    for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
                        if (j >= int'(r_idx)) n_tab[j] = r_tab[j + 1];
                    end
                    n_count = r_count - CW'(1);
                    n_state = pett_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            pett_pkg::ST_FLUSH: begin
                if (r_idx >= r_count || r_n == pett_pkg::MAX_RESULTS) begin
                    n_state = pett_pkg::ST_DONE;
                end else if (ent.pending) begin
                    new_vld              = 1'b1;
                    new_res.event_res    = pett_pkg::EV_REMOVED;
                    new_res.kind_out     = ent.kind;
                    new_res.instance_out = ent.id;
                    new_res.reason_out   = ent.why;
                    for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
                        if (j >= int'(r_idx)) n_tab[j] = r_tab[j + 1];
                    end
                    n_count = r_count - CW'(1);
                    n_n     = r_n + 4'd1;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            pett_pkg::ST_DONE: begin
                n_state = pett_pkg::ST_IDLE;
            end
            default: n_state = pett_pkg::ST_IDLE;
        endcase

        // hold one result back so the final beat can carry last
        n_hold     = r_hold;
        n_hold_vld = r_hold_vld;
        n_out      = r_out;
        n_strobe   = 1'b0;
        if (new_vld) begin
            if (r_hold_vld) begin
                n_out      = r_hold;
                n_out.last = 1'b0;
                n_strobe   = 1'b1;
            end
            n_hold     = new_res;
            n_hold_vld = 1'b1;
        end else if (r_state == pett_pkg::ST_DONE && r_hold_vld) begin
            n_out      = r_hold;
            n_out.last = 1'b1;
            n_strobe   = 1'b1;
            n_hold_vld = 1'b0;
        end
    end

endmodule

// File: verif/tb_periodic_expiring_timer_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_expiring_timer_table_unit
// Drives apply, advance, remove and flush commands into the timer table and
// compares every event beat against a behavioural table kept alongside it.
// ----------------------------------------------------------------------------
module tb_periodic_expiring_timer_table_unit;

    localparam int DEPTH = 8;
    localparam logic [1:0] POL_INFINITE = 2'd2;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    pett_pkg::t_in   i_item;
    logic            o_strobe;
    pett_pkg::t_out  o_result;

    periodic_expiring_timer_table_unit #(.MAX_ENTRIES(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result)
    );

    typedef struct {
        logic [15:0]  kind;
        logic [31:0]  id;
        logic [1:0]   policy;
        logic [23:0]  period;
        logic [23:0]  phase;
        longint       left;
        bit           pending;
    } t_timer;

    t_timer          timers[$];
    logic [31:0]     next_id;
    pett_pkg::t_out  expected_events[$];
    int              n_errors;
    bit              idle_on;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic pett_pkg::t_out mk_event(input logic [2:0] ev,
                                                input logic [15:0] kind,
                                                input logic [31:0] id,
                                                input logic [2:0] why,
                                                input logic [15:0] ticks);
        pett_pkg::t_out r;
        r.event_res = ev;
        r.kind_out = kind;
        r.instance_out = id;
        r.reason_out = why;
        r.tick_count = ticks;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_events(input pett_pkg::t_in it);
        pett_pkg::t_out evs[$];
        t_timer         t;
        longint         sum;
        int             idx;
        case (pett_pkg::t_op'(it.op))
            pett_pkg::OP_APPLY: begin
                if (it.policy != pett_pkg::POL_INSTANT && timers.size() >= DEPTH) begin
                    evs = {evs, mk_event(pett_pkg::EV_FULL, it.effect_kind, 32'd0,
                                         3'd0, 16'd0)};
                end else begin
                    evs = {evs, mk_event(pett_pkg::EV_APPLIED, it.effect_kind, next_id,
                                         3'd0, 16'd0)};
                    if (it.policy == pett_pkg::POL_INSTANT) begin
                        evs = {evs, mk_event(pett_pkg::EV_REMOVED, it.effect_kind, next_id,
                                             3'd0, 16'd0)};
                    end else begin
                        t.kind = it.effect_kind;
                        t.id = next_id;
                        t.policy = it.policy;
                        t.period = it.tick_period;
                        t.phase = '0;
                        t.left = (it.policy == pett_pkg::POL_FIXED) ? longint'(it.lifetime)
                                                                     : -1;
                        t.pending = 0;
                        timers = {timers, t};
                    end
                    next_id++;
                end
            end
            pett_pkg::OP_ADVANCE: begin
                if (it.elapsed_ms != 0) begin
                    foreach (timers[i]) begin
                        if (timers[i].pending) continue;
                        if (timers[i].period != 0) begin
                            sum = longint'(timers[i].phase) + it.elapsed_ms;
                            timers[i].phase = 24'(sum % timers[i].period);
                            if (sum / timers[i].period != 0
                                    && evs.size() < pett_pkg::MAX_RESULTS)
                                evs = {evs, mk_event(pett_pkg::EV_TICKED, timers[i].kind,
                                    timers[i].id, 3'd0, 16'(sum / timers[i].period))};
                        end
                        if (timers[i].policy == pett_pkg::POL_FIXED) begin
                            timers[i].left -= it.elapsed_ms;
                            if (timers[i].left <= 0) timers[i].pending = 1;
                        end
                    end
                end
            end
            pett_pkg::OP_REMOVE: begin
                idx = -1;
                foreach (timers[i]) if (idx < 0 && timers[i].id == it.target_id) idx = i;
                if (idx >= 0) begin
                    evs = {evs, mk_event(pett_pkg::EV_REMOVED, timers[idx].kind,
                                         timers[idx].id, it.why, 16'd0)};
                    timers.delete(idx);
                end else begin
                    evs = {evs, mk_event(pett_pkg::EV_NOTFOUND, 16'd0, it.target_id,
                                         3'd0, 16'd0)};
                end
            end
            default: begin
                idx = 0;
                while (idx < timers.size() && evs.size() < pett_pkg::MAX_RESULTS) begin
                    if (timers[idx].pending) begin
                        evs = {evs, mk_event(pett_pkg::EV_REMOVED, timers[idx].kind,
                                             timers[idx].id, 3'd0, 16'd0)};
                        timers.delete(idx);
                    end else begin
                        idx++;
                    end
                end
            end
        endcase
        if (evs.size() > 0) evs[$].last = 1'b1;
        foreach (evs[i]) expected_events = {expected_events, evs[i]};
    endtask

    always @(posedge i_clk) begin
        pett_pkg::t_out exp_ev;
        if (i_rst_n && o_strobe) begin
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event beat %0d", o_result.event_res));
            end else begin
                exp_ev = expected_events.pop_front();
                if (o_result.event_res !== exp_ev.event_res)
                    report($sformatf("event %0d, want %0d", o_result.event_res,
                                     exp_ev.event_res));
                if (o_result.kind_out !== exp_ev.kind_out)
                    report($sformatf("kind %h, want %h", o_result.kind_out, exp_ev.kind_out));
                if (o_result.instance_out !== exp_ev.instance_out)
                    report($sformatf("instance %h, want %h", o_result.instance_out,
                                     exp_ev.instance_out));
                if (o_result.reason_out !== exp_ev.reason_out)
                    report($sformatf("reason %0d, want %0d", o_result.reason_out,
                                     exp_ev.reason_out));
                if (o_result.tick_count !== exp_ev.tick_count)
                    report($sformatf("ticks %0d, want %0d", o_result.tick_count,
                                     exp_ev.tick_count));
                if (o_result.last !== exp_ev.last)
                    report($sformatf("last %b, want %b", o_result.last, exp_ev.last));
            end
        end
    end

    function automatic pett_pkg::t_in blank_cmd(input pett_pkg::t_op op);
        pett_pkg::t_in it;
        it = '0;
        it.op = op;
        it.effect_kind = 16'($urandom);
        it.target_id = $urandom;
        it.why = 3'($urandom);
        it.tick_period = 24'($urandom);
        it.lifetime = 24'($urandom);
        it.elapsed_ms = 16'($urandom);
        it.policy = 2'($urandom);
        return it;
    endfunction

    task automatic send_cmd(input pett_pkg::t_in it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_events(it);
    endtask

    task automatic apply_cmd(input logic [1:0] pol, input logic [15:0] kind,
                             input logic [23:0] per, input logic [23:0] dur);
        pett_pkg::t_in it;
        it = blank_cmd(pett_pkg::OP_APPLY);
        it.policy = pol;
        it.effect_kind = kind;
        it.tick_period = per;
        it.lifetime = dur;
        send_cmd(it);
    endtask

    task automatic advance_cmd(input logic [15:0] dt);
        pett_pkg::t_in it;
        it = blank_cmd(pett_pkg::OP_ADVANCE);
        it.elapsed_ms = dt;
        send_cmd(it);
    endtask

    task automatic remove_cmd(input logic [31:0] id, input logic [2:0] why);
        pett_pkg::t_in it;
        it = blank_cmd(pett_pkg::OP_REMOVE);
        it.target_id = id;
        it.why = why;
        send_cmd(it);
    endtask

    task automatic test_directed;
        apply_cmd(pett_pkg::POL_INSTANT, 16'hffff, 24'hffffff, 24'd0);
        apply_cmd(pett_pkg::POL_FIXED, 16'h0000, 24'd1, 24'd0);
        apply_cmd(POL_INFINITE, 16'h1234, 24'hffffff, 24'hffffff);
        apply_cmd(2'd3, 16'h5555, 24'd7, 24'hffffff);
        apply_cmd(pett_pkg::POL_FIXED, 16'haaaa, 24'd0, 24'hffffff);
        advance_cmd(16'd0);
        advance_cmd(16'hffff);
        advance_cmd(16'd1);
        remove_cmd(32'd2, 3'd7);
        remove_cmd(32'hffffffff, 3'd5);
        send_cmd(blank_cmd(pett_pkg::OP_FLUSH));
        send_cmd(blank_cmd(pett_pkg::OP_FLUSH));
        repeat (7) apply_cmd(POL_INFINITE, 16'($urandom), 24'($urandom_range(1, 40)), 24'd0);
        apply_cmd(pett_pkg::POL_FIXED, 16'hbeef, 24'd3, 24'd9);
        apply_cmd(pett_pkg::POL_INSTANT, 16'hcafe, 24'd0, 24'd0);
        advance_cmd(16'd200);
        remove_cmd(next_id - 32'd3, 3'd1);
    endtask

    task automatic test_random(input int count);
        pett_pkg::t_in it;
        int            sel;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            it = blank_cmd(pett_pkg::OP_APPLY);
            if (sel < 40) begin
                it.policy = 2'($urandom_range(0, 3));
                it.tick_period = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                               : 24'($urandom_range(0, 50));
                it.lifetime = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                            : 24'($urandom_range(0, 200));
            end else if (sel < 70) begin
                it.op = pett_pkg::OP_ADVANCE;
                it.elapsed_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                              : 16'($urandom_range(0, 60));
            end else if (sel < 88) begin
                it.op = pett_pkg::OP_REMOVE;
                if (timers.size() > 0 && $urandom_range(0, 3) != 0)
                    it.target_id = timers[$urandom_range(0, timers.size() - 1)].id;
                else if ($urandom_range(0, 1))
                    it.target_id = next_id + 32'($urandom_range(0, 5));
            end else begin
                it.op = pett_pkg::OP_FLUSH;
            end
            send_cmd(it);
        end
    endtask

    task automatic test_instant_run;
        // advance the id counter with instant applies, even on a full table
        repeat (20) apply_cmd(pett_pkg::POL_INSTANT, 16'($urandom), 24'd0, 24'd0);
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        n_errors = 0;
        next_id = 32'd1;
        idle_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(280);
        test_instant_run();
        idle_on = 1'b0;
        test_random(60);
        start <= 1'b0;
        guard = 0;
        while (expected_events.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
        if (n_errors == 0 && expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/pett_pkg.sv
rtl/core/periodic_expiring_timer_table_unit.sv
verif/tb_periodic_expiring_timer_table_unit.sv
